// ===== sv/wpt_pkg.sv =====
package wpt_pkg;

	localparam int COORD_BITS = 24;
	localparam int MAX_POINTS = 256;

	localparam int GRID_W    = 10;
	localparam int GSIZE_W   = 8;
	localparam int RADIUS_W  = 16;
	localparam int HEAD_W    = 16;
	localparam int FUNC_W    = 2;
	localparam int MODE_W    = 2;
	localparam int RAW_W     = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = COORD_BITS;

	localparam int ADDR_W  = $clog2(MAX_POINTS);
	localparam int CNT_W   = $clog2(MAX_POINTS + 1);
	localparam int ENTRY_W = 2 * COORD_BITS;

	localparam int MUL_W  = COORD_BITS + 1;
	localparam int PROD_W = 2 * MUL_W;

	// scaled grid coordinate: grid * size, then << 8
	localparam int RAW_SCALE_W = GRID_W + GSIZE_W;
	localparam int SCALE_W     = RAW_SCALE_W + 8;
	localparam int SUM_W       = ((SCALE_W > COORD_BITS) ? SCALE_W : COORD_BITS) + 2;

	localparam logic signed [SUM_W-1:0] COORD_MAX = (SUM_W'(1) <<< (COORD_BITS - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] COORD_MIN = -COORD_MAX - SUM_W'(1);

	localparam logic [FUNC_W-1:0] FN_LOAD  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_TRACK = 2'd1;
	localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd2;

	localparam logic [MODE_W-1:0] MODE_NONE     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TRACKING = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FINISHED = 2'd2;

	localparam logic [RAW_W-1:0] RAW_NONE = 2'd0;
	localparam logic [RAW_W-1:0] RAW_ONE  = 2'd1;
	localparam logic [RAW_W-1:0] RAW_TWO  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS_FINAL = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HEADING      = 3'd5;

	localparam logic [GSIZE_W-1:0]  GSIZE_RST        = 8'd20;
	localparam logic [RADIUS_W-1:0] RADIUS_RST       = 16'd2560;
	localparam logic [RADIUS_W-1:0] RADIUS_FINAL_RST = 16'd256;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_CROSS_A,
		ST_CROSS_B,
		ST_CROSS_CMP,
		ST_APP_X,
		ST_APP_Y,
		ST_APP_W,
		ST_LOAD_END,
		ST_TRK_DIFF,
		ST_TRK_SQX,
		ST_TRK_SQY,
		ST_TRK_RSQ,
		ST_TRK_CMP,
		ST_TRK_NEXT
	} state_t;

	// (scaled << 8) + offset, clamped to the signed coordinate range
	function automatic logic signed [COORD_BITS-1:0] sat_coord(
		input logic [RAW_SCALE_W-1:0] scaled,
		input logic signed [COORD_BITS-1:0] off
	);
		logic signed [SUM_W-1:0] v;
		v = $signed({{(SUM_W-SCALE_W){1'b0}}, scaled, 8'h00}) + SUM_W'(off);
		if (v > COORD_MAX) begin
			v = COORD_MAX;
		end else if (v < COORD_MIN) begin
			v = COORD_MIN;
		end
		return v[COORD_BITS-1:0];
	endfunction

endpackage

// ===== sv/wpt_ram.sv =====
module wpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/waypoint_path_tracker.sv =====
// channel   signals                                              direction  handshake
// command   start, busy, func, grid_x, grid_y, last_point,       in         start & !busy
//           pos_x, pos_y
// result    done, target_x, target_y, target_heading,            out        done, one cycle
//           tracker_mode, waypoint_index
// config    cfg_valid, cfg_ready, cfg_index, cfg_data            in         cfg_valid & cfg_ready
//
// one shared 25x25 multiplier under a sequencer; busy stays high while a command runs.
// a position update that moves on to a further waypoint reads the path memory a second time.
// a raw point may run the cross-product multiplies and up to two appends, each
// through the shared multiplier. reset needs no clearing pass; cfg_ready is always high.
// results cannot be stalled: done marks the beat for exactly one cycle.
module waypoint_path_tracker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [wpt_pkg::FUNC_W-1:0]             func,
	input  logic [wpt_pkg::GRID_W-1:0]             grid_x,
	input  logic [wpt_pkg::GRID_W-1:0]             grid_y,
	input  logic                                   last_point,
	input  logic signed [wpt_pkg::COORD_BITS-1:0]  pos_x,
	input  logic signed [wpt_pkg::COORD_BITS-1:0]  pos_y,
	output logic                                   done,
	output logic signed [wpt_pkg::COORD_BITS-1:0]  target_x,
	output logic signed [wpt_pkg::COORD_BITS-1:0]  target_y,
	output logic signed [wpt_pkg::HEAD_W-1:0]      target_heading,
	output logic [wpt_pkg::MODE_W-1:0]             tracker_mode,
	output logic [wpt_pkg::CNT_W-1:0]              waypoint_index,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [wpt_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [wpt_pkg::CFG_W-1:0]              cfg_data
);

	wpt_pkg::state_t state_q, state_d;

	// latched command
	logic [wpt_pkg::FUNC_W-1:0]            func_q;
	logic [wpt_pkg::GRID_W-1:0]            gx_q, gy_q;
	logic                                  last_q;
	logic signed [wpt_pkg::COORD_BITS-1:0] px_q, py_q;

	// config
	logic [wpt_pkg::GSIZE_W-1:0]           gsize_q;
	logic signed [wpt_pkg::COORD_BITS-1:0] offx_q, offy_q;
	logic [wpt_pkg::RADIUS_W-1:0]          rad_q, radf_q;
	logic signed [wpt_pkg::HEAD_W-1:0]     head_q;

	// tracker state
	logic [wpt_pkg::CNT_W-1:0]             len_q, len_d;
	logic [wpt_pkg::CNT_W-1:0]             idx_q, idx_d;
	logic [wpt_pkg::MODE_W-1:0]            mode_q, mode_d;
	logic [wpt_pkg::RAW_W-1:0]             raw_q, raw_d;
	logic [wpt_pkg::GRID_W-1:0]            prev_x_q, prev_y_q, pp_x_q, pp_y_q;
	logic signed [wpt_pkg::COORD_BITS-1:0] held_x_q, held_x_d, held_y_q, held_y_d;

	// working registers
	logic                                  app_cur_q, app_cur_d;
	logic signed [wpt_pkg::COORD_BITS-1:0] coord_x_q;
	logic signed [wpt_pkg::COORD_BITS-1:0] tx_q, ty_q;
	logic signed [wpt_pkg::MUL_W-1:0]      dx_q, dy_q;
	logic signed [wpt_pkg::PROD_W-1:0]     prod_q;
	logic [wpt_pkg::PROD_W-1:0]            acc_q, acc_d;
	logic                                  done_q, done_d;

	// shared multiplier
	logic signed [wpt_pkg::MUL_W-1:0]      mul_a, mul_b;
	logic signed [wpt_pkg::PROD_W-1:0]     mul_p;

	// path memory
	logic                                  ram_we;
	logic [wpt_pkg::ADDR_W-1:0]            ram_raddr;
	logic [wpt_pkg::ENTRY_W-1:0]           ram_wdata, ram_rdata;
	logic signed [wpt_pkg::COORD_BITS-1:0] rd_x, rd_y, coord_y;

	logic signed [wpt_pkg::GRID_W:0]       dx1, dy1, dx2, dy2;
	logic [wpt_pkg::GRID_W-1:0]            gx_sel, gy_sel;
	logic [wpt_pkg::RADIUS_W-1:0]          r_sel;
	logic [wpt_pkg::CNT_W-1:0]             idx_inc;

	assign busy           = (state_q != wpt_pkg::ST_IDLE);
	assign done           = done_q;
	assign target_x       = held_x_q;
	assign target_y       = held_y_q;
	assign target_heading = head_q;
	assign tracker_mode   = mode_q;
	assign waypoint_index = idx_q;
	assign cfg_ready      = 1'b1;

	assign dx1 = $signed({1'b0, prev_x_q}) - $signed({1'b0, pp_x_q});
	assign dy1 = $signed({1'b0, prev_y_q}) - $signed({1'b0, pp_y_q});
	assign dx2 = $signed({1'b0, gx_q}) - $signed({1'b0, prev_x_q});
	assign dy2 = $signed({1'b0, gy_q}) - $signed({1'b0, prev_y_q});

	assign gx_sel  = app_cur_q ? gx_q : prev_x_q;
	assign gy_sel  = app_cur_q ? gy_q : prev_y_q;
	assign idx_inc = idx_q + wpt_pkg::CNT_W'(1);
	assign r_sel   = (idx_inc == len_q) ? radf_q : rad_q;

	assign rd_x = ram_rdata[wpt_pkg::ENTRY_W-1:wpt_pkg::COORD_BITS];
	assign rd_y = ram_rdata[wpt_pkg::COORD_BITS-1:0];

	assign coord_y   = wpt_pkg::sat_coord(prod_q[wpt_pkg::RAW_SCALE_W-1:0], offy_q);
	assign ram_wdata = {coord_x_q, coord_y};

	assign mul_p = mul_a * mul_b;

	wpt_ram #(
		.WIDTH (wpt_pkg::ENTRY_W),
		.DEPTH (wpt_pkg::MAX_POINTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (len_q[wpt_pkg::ADDR_W-1:0]),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= wpt_pkg::ST_IDLE;
			gsize_q   <= wpt_pkg::GSIZE_RST;
			offx_q    <= '0;
			offy_q    <= '0;
			rad_q     <= wpt_pkg::RADIUS_RST;
			radf_q    <= wpt_pkg::RADIUS_FINAL_RST;
			head_q    <= '0;
			len_q     <= '0;
			idx_q     <= '0;
			mode_q    <= wpt_pkg::MODE_NONE;
			raw_q     <= wpt_pkg::RAW_NONE;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			pp_x_q    <= '0;
			pp_y_q    <= '0;
			held_x_q  <= '0;
			held_y_q  <= '0;
			app_cur_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			len_q     <= len_d;
			idx_q     <= idx_d;
			mode_q    <= mode_d;
			raw_q     <= raw_d;
			held_x_q  <= held_x_d;
			held_y_q  <= held_y_d;
			app_cur_q <= app_cur_d;
			done_q    <= done_d;
			if (cfg_valid) begin
				unique case (cfg_index)
					wpt_pkg::REG_GRID_SIZE:    gsize_q <= cfg_data[wpt_pkg::GSIZE_W-1:0];
					wpt_pkg::REG_OFFSET_X:     offx_q  <= cfg_data[wpt_pkg::COORD_BITS-1:0];
					wpt_pkg::REG_OFFSET_Y:     offy_q  <= cfg_data[wpt_pkg::COORD_BITS-1:0];
					wpt_pkg::REG_RADIUS:       rad_q   <= cfg_data[wpt_pkg::RADIUS_W-1:0];
					wpt_pkg::REG_RADIUS_FINAL: radf_q  <= cfg_data[wpt_pkg::RADIUS_W-1:0];
					wpt_pkg::REG_HEADING:      head_q  <= cfg_data[wpt_pkg::HEAD_W-1:0];
					default: ;
				endcase
			end
			if (state_q == wpt_pkg::ST_LOAD_END) begin
				prev_x_q <= gx_q;
				prev_y_q <= gy_q;
				if (raw_q != wpt_pkg::RAW_NONE) begin
					pp_x_q <= prev_x_q;
					pp_y_q <= prev_y_q;
				end
			end
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		acc_q  <= acc_d;
		if (state_q == wpt_pkg::ST_IDLE && start) begin
			func_q <= func;
			gx_q   <= grid_x;
			gy_q   <= grid_y;
			last_q <= last_point;
			px_q   <= pos_x;
			py_q   <= pos_y;
		end
		if (state_q == wpt_pkg::ST_APP_Y) begin
			coord_x_q <= wpt_pkg::sat_coord(prod_q[wpt_pkg::RAW_SCALE_W-1:0], offx_q);
		end
		if (state_q == wpt_pkg::ST_TRK_DIFF) begin
			tx_q <= rd_x;
			ty_q <= rd_y;
			dx_q <= wpt_pkg::MUL_W'(rd_x) - wpt_pkg::MUL_W'(px_q);
			dy_q <= wpt_pkg::MUL_W'(rd_y) - wpt_pkg::MUL_W'(py_q);
		end
	end

	always_comb begin
		state_d   = state_q;
		len_d     = len_q;
		idx_d     = idx_q;
		mode_d    = mode_q;
		raw_d     = raw_q;
		held_x_d  = held_x_q;
		held_y_d  = held_y_q;
		app_cur_d = app_cur_q;
		acc_d     = acc_q;
		done_d    = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		ram_we    = 1'b0;
		ram_raddr = idx_q[wpt_pkg::ADDR_W-1:0];
		unique case (state_q)
			wpt_pkg::ST_IDLE: begin
				if (start) begin
					state_d = wpt_pkg::ST_DECODE;
				end
			end
			wpt_pkg::ST_DECODE: begin
				unique case (func_q)
					wpt_pkg::FN_LOAD: begin
						if (raw_q == wpt_pkg::RAW_NONE) begin
							// first point of a new path
							len_d     = '0;
							mode_d    = wpt_pkg::MODE_FINISHED;
							app_cur_d = 1'b1;
							state_d   = wpt_pkg::ST_APP_X;
						end else if (raw_q == wpt_pkg::RAW_TWO) begin
							state_d = wpt_pkg::ST_CROSS_A;
						end else if (last_q) begin
							app_cur_d = 1'b1;
							state_d   = wpt_pkg::ST_APP_X;
						end else begin
							state_d = wpt_pkg::ST_LOAD_END;
						end
					end
					wpt_pkg::FN_TRACK: begin
						if (mode_q != wpt_pkg::MODE_TRACKING) begin
							done_d  = 1'b1;
							state_d = wpt_pkg::ST_IDLE;
						end else if (idx_q >= len_q) begin
							mode_d  = wpt_pkg::MODE_FINISHED;
							done_d  = 1'b1;
							state_d = wpt_pkg::ST_IDLE;
						end else begin
							state_d = wpt_pkg::ST_TRK_DIFF;
						end
					end
					wpt_pkg::FN_CLEAR: begin
						len_d   = '0;
						raw_d   = wpt_pkg::RAW_NONE;
						mode_d  = wpt_pkg::MODE_FINISHED;
						state_d = wpt_pkg::ST_IDLE;
					end
					default: begin
						state_d = wpt_pkg::ST_IDLE;
					end
				endcase
			end
			wpt_pkg::ST_CROSS_A: begin
				mul_a   = wpt_pkg::MUL_W'(dx1);
				mul_b   = wpt_pkg::MUL_W'(dy2);
				state_d = wpt_pkg::ST_CROSS_B;
			end
			wpt_pkg::ST_CROSS_B: begin
				acc_d   = $unsigned(prod_q);
				mul_a   = wpt_pkg::MUL_W'(dx2);
				mul_b   = wpt_pkg::MUL_W'(dy1);
				state_d = wpt_pkg::ST_CROSS_CMP;
			end
			wpt_pkg::ST_CROSS_CMP: begin
				if (acc_q != $unsigned(prod_q)) begin
					// direction changes at the previous point
					app_cur_d = 1'b0;
					state_d   = wpt_pkg::ST_APP_X;
				end else if (last_q) begin
					app_cur_d = 1'b1;
					state_d   = wpt_pkg::ST_APP_X;
				end else begin
					state_d = wpt_pkg::ST_LOAD_END;
				end
			end
			wpt_pkg::ST_APP_X: begin
				mul_a   = wpt_pkg::MUL_W'($signed({1'b0, gx_sel}));
				mul_b   = wpt_pkg::MUL_W'($signed({1'b0, gsize_q}));
				state_d = wpt_pkg::ST_APP_Y;
			end
			wpt_pkg::ST_APP_Y: begin
				mul_a   = wpt_pkg::MUL_W'($signed({1'b0, gy_sel}));
				mul_b   = wpt_pkg::MUL_W'($signed({1'b0, gsize_q}));
				state_d = wpt_pkg::ST_APP_W;
			end
			wpt_pkg::ST_APP_W: begin
				// points that find the memory full are dropped
				if (len_q < wpt_pkg::CNT_W'(wpt_pkg::MAX_POINTS)) begin
					ram_we = 1'b1;
					len_d  = len_q + wpt_pkg::CNT_W'(1);
				end
				if (!app_cur_q && last_q) begin
					app_cur_d = 1'b1;
					state_d   = wpt_pkg::ST_APP_X;
				end else begin
					state_d = wpt_pkg::ST_LOAD_END;
				end
			end
			wpt_pkg::ST_LOAD_END: begin
				raw_d = (raw_q == wpt_pkg::RAW_NONE) ? wpt_pkg::RAW_ONE : wpt_pkg::RAW_TWO;
				if (last_q) begin
					idx_d  = (len_q > wpt_pkg::CNT_W'(1)) ? wpt_pkg::CNT_W'(1) : '0;
					mode_d = wpt_pkg::MODE_TRACKING;
					raw_d  = wpt_pkg::RAW_NONE;
				end
				state_d = wpt_pkg::ST_IDLE;
			end
			wpt_pkg::ST_TRK_DIFF: begin
				state_d = wpt_pkg::ST_TRK_SQX;
			end
			wpt_pkg::ST_TRK_SQX: begin
				mul_a   = dx_q;
				mul_b   = dx_q;
				state_d = wpt_pkg::ST_TRK_SQY;
			end
			wpt_pkg::ST_TRK_SQY: begin
				acc_d   = $unsigned(prod_q);
				mul_a   = dy_q;
				mul_b   = dy_q;
				state_d = wpt_pkg::ST_TRK_RSQ;
			end
			wpt_pkg::ST_TRK_RSQ: begin
				acc_d   = acc_q + $unsigned(prod_q);
				mul_a   = wpt_pkg::MUL_W'($signed({1'b0, r_sel}));
				mul_b   = wpt_pkg::MUL_W'($signed({1'b0, r_sel}));
				state_d = wpt_pkg::ST_TRK_CMP;
			end
			wpt_pkg::ST_TRK_CMP: begin
				if (acc_q <= $unsigned(prod_q)) begin
					idx_d = idx_inc;
					if (idx_inc >= len_q) begin
						mode_d   = wpt_pkg::MODE_FINISHED;
						held_x_d = tx_q;
						held_y_d = ty_q;
						done_d   = 1'b1;
						state_d  = wpt_pkg::ST_IDLE;
					end else begin
						ram_raddr = idx_inc[wpt_pkg::ADDR_W-1:0];
						state_d   = wpt_pkg::ST_TRK_NEXT;
					end
				end else begin
					held_x_d = tx_q;
					held_y_d = ty_q;
					done_d   = 1'b1;
					state_d  = wpt_pkg::ST_IDLE;
				end
			end
			wpt_pkg::ST_TRK_NEXT: begin
				held_x_d = rd_x;
				held_y_d = rd_y;
				done_d   = 1'b1;
				state_d  = wpt_pkg::ST_IDLE;
			end
			default: begin
				state_d = wpt_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/wpt_checker.sv =====
module wpt_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [wpt_pkg::MODE_W-1:0]  tracker_mode,
	input logic [wpt_pkg::CNT_W-1:0]   waypoint_index
);

	// an accepted command raises busy in the cycle after it is taken
	assert property (@(posedge clk) disable iff (!arst_n) start && !busy |=> busy)
		else $error("accepted command did not raise busy");

	// idle without a command stays idle
	assert property (@(posedge clk) disable iff (!arst_n) !start && !busy |=> !busy)
		else $error("busy rose without an accepted command");

	// a result beat comes once the sequencer is back at rest, and never twice in a row
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy ##1 !done)
		else $error("result beat while busy or repeated");

	// before any path is loaded the pursued index is still zero
	assert property (@(posedge clk) disable iff (!arst_n)
		done && tracker_mode == wpt_pkg::MODE_NONE |-> waypoint_index == '0)
		else $error("nonzero waypoint index with no path");

endmodule

bind waypoint_path_tracker wpt_checker u_wpt_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import wpt_pkg::*;

	localparam logic [FUNC_W-1:0] FN_IGNORED = 2'd3;
	localparam int RANDOM_ITEMS  = 550;
	localparam int SETTLE_CYCLES = 16;
	localparam int STALL_LIMIT   = 400;

	typedef struct packed {
		logic [FUNC_W-1:0]            func;
		logic [GRID_W-1:0]            gx;
		logic [GRID_W-1:0]            gy;
		logic                         last;
		logic signed [COORD_BITS-1:0] px;
		logic signed [COORD_BITS-1:0] py;
	} command_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] tx;
		logic signed [COORD_BITS-1:0] ty;
		logic signed [HEAD_W-1:0]     heading;
		logic [MODE_W-1:0]            mode;
		logic [CNT_W-1:0]             index;
	} target_t;

	typedef enum int {AIM_EXACT, AIM_NEAR, AIM_RIM, AIM_BEYOND, AIM_FAR} aim_kind_t;

	class path_scoreboard;
		logic [GSIZE_W-1:0]           cell_cm;
		logic signed [COORD_BITS-1:0] off_x;
		logic signed [COORD_BITS-1:0] off_y;
		logic [RADIUS_W-1:0]          radius;
		logic [RADIUS_W-1:0]          radius_final;
		logic signed [HEAD_W-1:0]     heading;

		logic signed [COORD_BITS-1:0] wp_x [MAX_POINTS];
		logic signed [COORD_BITS-1:0] wp_y [MAX_POINTS];
		int                           n_wp;
		int                           aim_idx;
		logic [MODE_W-1:0]            tmode;
		int                           last_gx, last_gy, older_gx, older_gy;
		int                           raw_cnt;
		logic signed [COORD_BITS-1:0] held_x, held_y;

		target_t                      targets_due[$];
		int                           errors;

		function new();
			cell_cm      = GSIZE_RST;
			off_x        = '0;
			off_y        = '0;
			radius       = RADIUS_RST;
			radius_final = RADIUS_FINAL_RST;
			heading      = '0;
			foreach (wp_x[i]) begin
				wp_x[i] = '0;
				wp_y[i] = '0;
			end
			n_wp     = 0;
			aim_idx  = 0;
			tmode    = MODE_NONE;
			last_gx  = 0;
			last_gy  = 0;
			older_gx = 0;
			older_gy = 0;
			raw_cnt  = 0;
			held_x   = '0;
			held_y   = '0;
			errors   = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_GRID_SIZE:    cell_cm = data[GSIZE_W-1:0];
				REG_OFFSET_X:     off_x = data;
				REG_OFFSET_Y:     off_y = data;
				REG_RADIUS:       radius = data[RADIUS_W-1:0];
				REG_RADIUS_FINAL: radius_final = data[RADIUS_W-1:0];
				REG_HEADING:      heading = data[HEAD_W-1:0];
				default: ;
			endcase
		endfunction

		// grid cell -> Q15.8 cm, clamped to the coordinate range
		function logic signed [COORD_BITS-1:0] grid_to_cm(int g, logic signed [COORD_BITS-1:0] off);
			longint v, hi, lo;
			hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
			lo = -hi - 1;
			v = longint'(g) * longint'(cell_cm) * 256 + longint'(off);
			if (v > hi) v = hi;
			if (v < lo) v = lo;
			return v[COORD_BITS-1:0];
		endfunction

		function void keep_point(int x, int y);
			if (n_wp >= MAX_POINTS) return;
			wp_x[n_wp] = grid_to_cm(x, off_x);
			wp_y[n_wp] = grid_to_cm(y, off_y);
			n_wp++;
		endfunction

		function void take_point(int x, int y, bit last);
			longint dx1, dy1, dx2, dy2;
			if (raw_cnt == 0) begin
				n_wp  = 0;
				tmode = MODE_FINISHED;
				keep_point(x, y);
				raw_cnt = 1;
			end else begin
				if (raw_cnt >= 2) begin
					dx1 = last_gx - older_gx;
					dy1 = last_gy - older_gy;
					dx2 = x - last_gx;
					dy2 = y - last_gy;
					// a turn at the previous point keeps it
					if (dx1 * dy2 != dx2 * dy1) keep_point(last_gx, last_gy);
				end
				older_gx = last_gx;
				older_gy = last_gy;
				raw_cnt  = 2;
				if (last) keep_point(x, y);
			end
			last_gx = x;
			last_gy = y;
			if (last) begin
				aim_idx = (n_wp > 1) ? 1 : 0;
				tmode   = MODE_TRACKING;
				raw_cnt = 0;
			end
		endfunction

		function void advance(logic signed [COORD_BITS-1:0] px, logic signed [COORD_BITS-1:0] py);
			longint tx, ty, dx, dy;
			longint unsigned d2, r, r2;
			if (tmode != MODE_TRACKING) return;
			if (aim_idx >= n_wp || aim_idx >= MAX_POINTS) begin
				tmode = MODE_FINISHED;
				return;
			end
			tx = wp_x[aim_idx];
			ty = wp_y[aim_idx];
			dx = tx - px;
			dy = ty - py;
			d2 = longint'(dx * dx) + longint'(dy * dy);
			r  = (aim_idx + 1 == n_wp) ? radius_final : radius;
			r2 = r * r;
			if (d2 <= r2) begin
				aim_idx++;
				if (aim_idx >= n_wp) begin
					tmode = MODE_FINISHED;
				end else begin
					tx = wp_x[aim_idx];
					ty = wp_y[aim_idx];
				end
			end
			held_x = tx[COORD_BITS-1:0];
			held_y = ty[COORD_BITS-1:0];
		endfunction

		function void note_command(command_t c);
			target_t t;
			case (c.func)
				FN_LOAD: take_point(int'(c.gx), int'(c.gy), c.last);
				FN_TRACK: begin
					advance(c.px, c.py);
					t.tx      = held_x;
					t.ty      = held_y;
					t.heading = heading;
					t.mode    = tmode;
					t.index   = CNT_W'(aim_idx);
					targets_due = {targets_due, t};
				end
				FN_CLEAR: begin
					n_wp    = 0;
					raw_cnt = 0;
					tmode   = MODE_FINISHED;
				end
				default: ;
			endcase
		endfunction

		function void check_result(target_t got);
			target_t want;
			if (targets_due.size() == 0) begin
				$error("unexpected result beat: target_x %0d target_y %0d", got.tx, got.ty);
				errors++;
				return;
			end
			want = targets_due.pop_front();
			if (got.tx !== want.tx) begin
				$error("target_x expected %0d actual %0d", want.tx, got.tx);
				errors++;
			end
			if (got.ty !== want.ty) begin
				$error("target_y expected %0d actual %0d", want.ty, got.ty);
				errors++;
			end
			if (got.heading !== want.heading) begin
				$error("target_heading expected %0d actual %0d", want.heading, got.heading);
				errors++;
			end
			if (got.mode !== want.mode) begin
				$error("tracker_mode expected %0d actual %0d", want.mode, got.mode);
				errors++;
			end
			if (got.index !== want.index) begin
				$error("waypoint_index expected %0d actual %0d", want.index, got.index);
				errors++;
			end
		endfunction

		function int pending();
			return targets_due.size();
		endfunction

		function logic signed [COORD_BITS-1:0] aim_x();
			if (tmode == MODE_TRACKING && aim_idx < n_wp) return wp_x[aim_idx];
			return held_x;
		endfunction

		function logic signed [COORD_BITS-1:0] aim_y();
			if (tmode == MODE_TRACKING && aim_idx < n_wp) return wp_y[aim_idx];
			return held_y;
		endfunction

		function longint aim_radius();
			return (aim_idx + 1 == n_wp) ? radius_final : radius;
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic [FUNC_W-1:0]            func;
	logic [GRID_W-1:0]            grid_x;
	logic [GRID_W-1:0]            grid_y;
	logic                         last_point;
	logic signed [COORD_BITS-1:0] pos_x;
	logic signed [COORD_BITS-1:0] pos_y;
	logic                         done;
	logic signed [COORD_BITS-1:0] target_x;
	logic signed [COORD_BITS-1:0] target_y;
	logic signed [HEAD_W-1:0]     target_heading;
	logic [MODE_W-1:0]            tracker_mode;
	logic [CNT_W-1:0]             waypoint_index;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [CFG_IDX_W-1:0]         cfg_index;
	logic [CFG_W-1:0]             cfg_data;

	path_scoreboard sb = new();
	int  items_sent = 0;
	int  stall_cycles = 0;
	bit  quiet = 0;

	waypoint_path_tracker uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.func           (func),
		.grid_x         (grid_x),
		.grid_y         (grid_y),
		.last_point     (last_point),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.done           (done),
		.target_x       (target_x),
		.target_y       (target_y),
		.target_heading (target_heading),
		.tracker_mode   (tracker_mode),
		.waypoint_index (waypoint_index),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin : result_monitor
		target_t got;
		if (arst_n && done) begin
			got.tx      = target_x;
			got.ty      = target_y;
			got.heading = target_heading;
			got.mode    = tracker_mode;
			got.index   = waypoint_index;
			sb.check_result(got);
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	function automatic logic signed [COORD_BITS-1:0] rand_coord();
		return COORD_BITS'($urandom());
	endfunction

	function automatic longint clamp_coord(longint v);
		longint hi;
		hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	// extremes half of the time, else a draw from the typical span
	function automatic longint pick(longint lo, longint hi, longint mid_lo, longint mid_hi);
		case ($urandom_range(0, 3))
			0: return lo;
			1: return hi;
			default: return mid_lo + longint'($urandom_range(0, int'(mid_hi - mid_lo)));
		endcase
	endfunction

	// one command beat; start stays high across back-to-back beats
	task automatic issue(input command_t c);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		func       <= c.func;
		grid_x     <= c.gx;
		grid_y     <= c.gy;
		last_point <= c.last;
		pos_x      <= c.px;
		pos_y      <= c.py;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_command(c);
		if (c.func != FN_IGNORED) items_sent++;
	endtask

	task automatic send_op(input logic [FUNC_W-1:0] f);
		command_t c;
		c.func = f;
		c.gx   = GRID_W'($urandom());
		c.gy   = GRID_W'($urandom());
		c.last = 1'($urandom_range(0, 1));
		c.px   = rand_coord();
		c.py   = rand_coord();
		issue(c);
	endtask

	task automatic send_point(input int x, input int y, input bit last);
		command_t c;
		c.func = FN_LOAD;
		c.gx   = x[GRID_W-1:0];
		c.gy   = y[GRID_W-1:0];
		c.last = last;
		c.px   = rand_coord();
		c.py   = rand_coord();
		issue(c);
	endtask

	task automatic send_update(input longint px, input longint py);
		command_t c;
		c.func = FN_TRACK;
		c.gx   = GRID_W'($urandom());
		c.gy   = GRID_W'($urandom());
		c.last = 1'($urandom_range(0, 1));
		c.px   = px[COORD_BITS-1:0];
		c.py   = py[COORD_BITS-1:0];
		issue(c);
	endtask

	// position update placed relative to the waypoint now pursued
	task automatic chase(input aim_kind_t kind);
		longint ax, ay, r, ox, oy, t;
		ax = sb.aim_x();
		ay = sb.aim_y();
		r  = sb.aim_radius();
		ox = 0;
		oy = 0;
		case (kind)
			AIM_NEAR: begin
				ox = longint'($urandom_range(0, int'(r / 2)));
				oy = longint'($urandom_range(0, int'(r / 2)));
				if ($urandom_range(0, 1)) oy = -oy;
			end
			AIM_RIM: ox = r;
			AIM_BEYOND: ox = r + 1 + longint'($urandom_range(0, 100));
			AIM_FAR: begin
				ax = rand_coord();
				ay = rand_coord();
			end
			default: ;
		endcase
		if ($urandom_range(0, 1)) ox = -ox;
		if ($urandom_range(0, 1)) begin
			t  = ox;
			ox = oy;
			oy = t;
		end
		send_update(clamp_coord(ax + ox), clamp_coord(ay + oy));
	endtask

	// runs of steps in one direction, then a turn
	task automatic send_path(input int npts, input bit close);
		int x, y, dx, dy, run;
		x   = $urandom_range(0, 1023);
		y   = $urandom_range(0, 1023);
		dx  = 0;
		dy  = 0;
		run = 0;
		for (int k = 0; k < npts; k++) begin
			send_point(x, y, close && (k == npts - 1));
			if (run == 0) begin
				dx  = int'($urandom_range(0, 4)) - 2;
				dy  = int'($urandom_range(0, 4)) - 2;
				run = $urandom_range(1, 4);
			end
			run--;
			x = (x + dx < 0) ? 0 : ((x + dx > 1023) ? 1023 : x + dx);
			y = (y + dy < 0) ? 0 : ((y + dy > 1023) ? 1023 : y + dy);
		end
	endtask

	// hold off until every result is in and the block has gone idle
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0 || busy) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [GSIZE_W-1:0] gsize,
			input logic [COORD_BITS-1:0] ox, input logic [COORD_BITS-1:0] oy,
			input logic [RADIUS_W-1:0] r, input logic [RADIUS_W-1:0] rf,
			input logic [HEAD_W-1:0] hd);
		logic [CFG_W-1:0] vals [6];
		vals[REG_GRID_SIZE]    = CFG_W'(gsize);
		vals[REG_OFFSET_X]     = ox;
		vals[REG_OFFSET_Y]     = oy;
		vals[REG_RADIUS]       = CFG_W'(r);
		vals[REG_RADIUS_FINAL] = CFG_W'(rf);
		vals[REG_HEADING]      = CFG_W'(hd);
		for (int i = 0; i < 6; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			sb.write_reg(CFG_IDX_W'(i), vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int  directed_end, roll, npts;
		bit  full_done;
		longint cmin, cmax;
		cmax = (longint'(1) <<< (COORD_BITS - 1)) - 1;
		cmin = -cmax - 1;
		full_done = 0;

		arst_n     <= 1'b0;
		start      <= 1'b0;
		func       <= FN_LOAD;
		grid_x     <= '0;
		grid_y     <= '0;
		last_point <= 1'b0;
		pos_x      <= '0;
		pos_y      <= '0;
		cfg_valid  <= 1'b0;
		cfg_index  <= REG_GRID_SIZE;
		cfg_data   <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nothing loaded yet, then an ignored code
		send_update(0, 0);
		send_op(FN_IGNORED);
		// single-point path, far miss, then arrival
		send_point(1023, 1023, 1'b1);
		send_update(cmin, cmax);
		chase(AIM_EXACT);
		send_update(0, 0);
		// straight runs collapse, corners stay
		send_point(0, 0, 1'b0);
		send_point(1, 0, 1'b0);
		send_point(2, 0, 1'b0);
		send_point(2, 1, 1'b0);
		send_point(2, 2, 1'b0);
		send_point(0, 0, 1'b1);
		chase(AIM_RIM);
		chase(AIM_BEYOND);
		chase(AIM_EXACT);
		chase(AIM_RIM);
		// clear in the middle of a path
		send_point(5, 5, 1'b0);
		send_op(FN_CLEAR);
		send_update(0, 0);

		settle();
		program_regs(8'd255, COORD_BITS'(cmax), COORD_BITS'(cmax), '0, 16'hFFFF, 16'h8000);
		send_point(1023, 0, 1'b0);
		send_point(1023, 1023, 1'b1);
		send_update(cmin, cmin);
		settle();
		program_regs(8'd1, COORD_BITS'(cmin), COORD_BITS'(cmin), 16'hFFFF, '0, 16'h7FFF);
		send_point(0, 0, 1'b1);
		send_update(cmax, cmax);
		chase(AIM_EXACT);
		directed_end = items_sent;

		while (items_sent < directed_end + RANDOM_ITEMS) begin
			quiet = ($urandom_range(0, 3) == 0);
			roll  = $urandom_range(0, 19);
			if (!full_done && items_sent > directed_end + 30) begin
				// zigzag longer than the path memory, followed to its end
				send_op(FN_CLEAR);
				for (int k = 0; k < MAX_POINTS + 9; k++) begin
					send_point(k, (k % 2) * 3, k == MAX_POINTS + 8);
				end
				while (sb.tmode == MODE_TRACKING) chase(aim_kind_t'($urandom_range(0, 2)));
				full_done = 1;
			end else if (roll < 11) begin
				npts = $urandom_range(1, 12);
				send_path(npts, 1'b1);
				repeat ($urandom_range(1, 2 * npts + 2)) chase(aim_kind_t'($urandom_range(0, 4)));
			end else if (roll < 13) begin
				repeat ($urandom_range(1, 6)) send_op(FUNC_W'($urandom_range(0, 3)));
			end else if (roll < 15) begin
				send_path($urandom_range(1, 5), 1'b0);
				case ($urandom_range(0, 2))
					0: send_op(FN_CLEAR);
					1: repeat ($urandom_range(1, 3)) chase(aim_kind_t'($urandom_range(0, 4)));
					default: ;
				endcase
			end else if (roll < 17) begin
				settle();
				program_regs(GSIZE_W'(pick(1, 255, 1, 40)),
					COORD_BITS'(pick(cmin, cmax, -(1 << 20), 1 << 20)),
					COORD_BITS'(pick(cmin, cmax, -(1 << 20), 1 << 20)),
					RADIUS_W'(pick(0, 65535, 0, 8000)),
					RADIUS_W'(pick(0, 65535, 0, 3000)),
					HEAD_W'(pick(-32768, 32767, -32768, 32767)));
			end else if (roll < 18) begin
				settle();
			end else begin
				repeat ($urandom_range(1, 4)) chase(AIM_FAR);
			end
		end

		settle();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/wpt_pkg.sv
sv/wpt_ram.sv
sv/waypoint_path_tracker.sv
sv/wpt_checker.sv
verif/testbench.sv
